[rtl/pbm_pkg.sv]
// ============================================================================
// pbm_pkg
// Types, character codes, phase and status codes shared by the P1 parser.
// ============================================================================
package pbm_pkg;

    // Default largest accepted image dimension
    localparam int DEF_MAX_DIM = 4095;

    // Characters the parser looks for
    localparam logic [7:0] CH_P     = 8'h50;  // 'P'
    localparam logic [7:0] CH_ONE   = 8'h31;  // '1'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_HT    = 8'h09;

    // Parse phase
    typedef enum logic [3:0] {
        PH_MAGIC_P   = 4'd0,
        PH_MAGIC_1   = 4'd1,
        PH_MAGIC_EOL = 4'd2,
        PH_MAGIC_LF  = 4'd3,
        PH_LINE      = 4'd4,
        PH_COMMENT   = 4'd5,
        PH_W_LEAD    = 4'd6,
        PH_W_DIG     = 4'd7,
        PH_H_LEAD    = 4'd8,
        PH_H_DIG     = 4'd9,
        PH_PIXELS    = 4'd10,
        PH_TRAIL     = 4'd11,
        PH_DONE      = 4'd12
    } t_phase;

    // Sticky status codes
    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_BAD_MAGIC   = 4'd1,
        ST_HEADER_EOF  = 4'd2,
        ST_BAD_WIDTH   = 4'd3,
        ST_NO_SEP_W    = 4'd4,
        ST_BAD_HEIGHT  = 4'd5,
        ST_NO_SEP_H    = 4'd6,
        ST_TOO_FEW     = 4'd7,
        ST_TOO_MANY    = 4'd8
    } t_status;

    // Input item
    typedef struct packed {
        logic [7:0] byte_req;
        logic       end_of_file;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic        pixel_valid;
        logic        pixel_black;
        logic [11:0] column;
        logic [11:0] row;
        logic [11:0] image_width;
        logic [11:0] image_height;
        t_status     status;
        logic        done_res;
    } t_out_item;

    // HT, LF, VT, FF, CR or space
    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SPACE) || ((b >= CH_HT) && (b <= CH_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= (CH_ZERO + 8'd9));
    endfunction

    // Space or LF, the only separators allowed after a number
    function automatic logic is_sep(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_LF);
    endfunction

endpackage

[rtl/pbm_acc.sv]
// ============================================================================
// pbm_acc
// Saturating decimal accumulate: value * 10 + digit, clamped to MAX_DIM + 1.
// ============================================================================
module pbm_acc #(
    parameter int MAX_DIM = 4095,
    parameter int AW      = 12
) (
    input  logic [AW-1:0] i_acc,
    input  logic [3:0]    i_digit,
    output logic [AW-1:0] o_value
);
    localparam logic [AW+3:0] MAXW = (AW+4)'(MAX_DIM);

    logic [AW+3:0] w_wide;
    logic [AW+3:0] w_acc_ext;

    // Times ten as two shifts, plus the digit
    assign w_acc_ext = {4'd0, i_acc};
    assign w_wide    = (w_acc_ext << 3) + (w_acc_ext << 1) + {{AW{1'b0}}, i_digit};

    // Clamp once the running value has gone past the limit
    always_comb begin
        if ((w_acc_ext > MAXW) || (w_wide > MAXW)) begin
            o_value = AW'(MAXW + 1'b1);
        end else begin
            o_value = w_wide[AW-1:0];
        end
    end
endmodule

[rtl/pbm_core.sv]
// ============================================================================
// pbm_core
// Parse state registers and the single-pass next-state logic for one byte.
// ============================================================================
module pbm_core #(
    parameter int MAX_DIM = 4095,
    parameter int AW      = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  pbm_pkg::t_in_item  i_in,
    output pbm_pkg::t_out_item o_item
);
    import pbm_pkg::*;

    localparam logic [AW-1:0] MAXA = AW'(MAX_DIM);
    localparam logic [AW-1:0] ONE  = AW'(1);

    t_phase        r_phase,  n_phase;
    t_status       r_err,    n_err;
    logic [AW-1:0] r_acc,    n_acc;
    logic [AW-1:0] r_width,  n_width;
    logic [AW-1:0] r_height, n_height;
    logic [AW-1:0] r_col,    n_col;
    logic [AW-1:0] r_row,    n_row;

    logic [7:0]    w_b;
    logic          w_digit;
    logic          w_ws;
    logic          w_sep;
    logic          w_val_bad;
    logic          w_acc_start;
    logic [AW-1:0] w_acc_src;
    logic [AW-1:0] w_acc_next;
    logic [AW-1:0] w_col_inc;
    logic [AW-1:0] w_row_inc;

    assign w_b       = i_in.byte_req;
    assign w_digit   = is_digit(w_b);
    assign w_ws      = is_ws(w_b);
    assign w_sep     = is_sep(w_b);
    assign w_val_bad = (r_acc == '0) || (r_acc > MAXA);
    assign w_col_inc = r_col + ONE;
    assign w_row_inc = r_row + ONE;

    // Start a fresh number from zero in the lead-in phases
    assign w_acc_start = (r_phase == PH_LINE) || (r_phase == PH_W_LEAD) ||
                         (r_phase == PH_H_LEAD);
    assign w_acc_src   = w_acc_start ? '0 : r_acc;

    pbm_acc #(
        .MAX_DIM (MAX_DIM),
        .AW      (AW)
    ) u_acc (
        .i_acc   (w_acc_src),
        .i_digit (w_b[3:0]),
        .o_value (w_acc_next)
    );

    // Advance the parse on one byte or end mark
    always_comb begin
        n_phase  = r_phase;
        n_err    = r_err;
        n_acc    = r_acc;
        n_width  = r_width;
        n_height = r_height;
        n_col    = r_col;
        n_row    = r_row;
        o_item   = '0;

        if ((r_err == ST_OK) && (r_phase != PH_DONE)) begin
            if (i_in.end_of_file) begin
                unique case (r_phase) inside
                    PH_MAGIC_P, PH_MAGIC_1, PH_MAGIC_EOL, PH_MAGIC_LF: n_err = ST_BAD_MAGIC;
                    PH_LINE, PH_COMMENT: n_err = ST_HEADER_EOF;
                    PH_W_LEAD:           n_err = ST_BAD_WIDTH;
                    PH_W_DIG:            n_err = w_val_bad ? ST_BAD_WIDTH : ST_NO_SEP_W;
                    PH_H_LEAD:           n_err = ST_BAD_HEIGHT;
                    PH_H_DIG:            n_err = w_val_bad ? ST_BAD_HEIGHT : ST_NO_SEP_H;
                    PH_PIXELS:           n_err = ST_TOO_FEW;
                    PH_TRAIL:            n_phase = PH_DONE;
                    default: ;
                endcase
            end else begin
                unique case (r_phase)
                    PH_MAGIC_P: begin
                        if (w_b == CH_P) n_phase = PH_MAGIC_1;
                        else             n_err   = ST_BAD_MAGIC;
                    end
                    PH_MAGIC_1: begin
                        if (w_b == CH_ONE) n_phase = PH_MAGIC_EOL;
                        else               n_err   = ST_BAD_MAGIC;
                    end
                    PH_MAGIC_EOL: begin
                        if (w_b == CH_LF)      n_phase = PH_LINE;
                        else if (w_b == CH_CR) n_phase = PH_MAGIC_LF;
                        else                   n_err   = ST_BAD_MAGIC;
                    end
                    PH_MAGIC_LF: begin
                        if (w_b == CH_LF) n_phase = PH_LINE;
                        else              n_err   = ST_BAD_MAGIC;
                    end
                    PH_LINE: begin
                        if (w_b == CH_HASH) begin
                            n_phase = PH_COMMENT;
                        end else if (w_digit) begin
                            n_acc   = w_acc_next;
                            n_phase = PH_W_DIG;
                        end else if (w_ws) begin
                            n_phase = PH_W_LEAD;
                        end else begin
                            n_err = ST_BAD_WIDTH;
                        end
                    end
                    PH_COMMENT: begin
                        if (w_b == CH_LF) n_phase = PH_LINE;
                    end
                    PH_W_LEAD: begin
                        if (w_digit) begin
                            n_acc   = w_acc_next;
                            n_phase = PH_W_DIG;
                        end else if (!w_ws) begin
                            n_err = ST_BAD_WIDTH;
                        end
                    end
                    PH_H_LEAD: begin
                        if (w_digit) begin
                            n_acc   = w_acc_next;
                            n_phase = PH_H_DIG;
                        end else if (!w_ws) begin
                            n_err = ST_BAD_HEIGHT;
                        end
                    end
                    PH_W_DIG: begin
                        if (w_digit) begin
                            n_acc = w_acc_next;
                        end else if (w_val_bad) begin
                            n_err = ST_BAD_WIDTH;
                        end else if (!w_sep) begin
                            n_err = ST_NO_SEP_W;
                        end else begin
                            n_width = r_acc;
                            n_acc   = '0;
                            n_phase = PH_H_LEAD;
                        end
                    end
                    PH_H_DIG: begin
                        if (w_digit) begin
                            n_acc = w_acc_next;
                        end else if (w_val_bad) begin
                            n_err = ST_BAD_HEIGHT;
                        end else if (!w_sep) begin
                            n_err = ST_NO_SEP_H;
                        end else begin
                            n_height = r_acc;
                            n_acc    = '0;
                            n_col    = ONE;
                            n_row    = ONE;
                            n_phase  = PH_PIXELS;
                        end
                    end
                    PH_PIXELS: begin
                        if ((w_b == CH_ZERO) || (w_b == CH_ONE)) begin
                            o_item.pixel_valid = 1'b1;
                            o_item.pixel_black = (w_b == CH_ONE);
                            o_item.column      = 12'(r_col);
                            o_item.row         = 12'(r_row);
                            // Wrap to the next row past the last column
                            if (w_col_inc > r_width) begin
                                n_col = ONE;
                                n_row = w_row_inc;
                                if (w_row_inc > r_height) n_phase = PH_TRAIL;
                            end else begin
                                n_col = w_col_inc;
                            end
                        end
                    end
                    PH_TRAIL: begin
                        if (!w_sep) n_err = ST_TOO_MANY;
                    end
                    default: ;
                endcase
            end
        end

        o_item.image_width  = 12'(n_width);
        o_item.image_height = 12'(n_height);
        o_item.status       = n_err;
        o_item.done_res     = (n_phase == PH_DONE);
    end

    // Hold state between accepted items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_MAGIC_P;
            r_err    <= ST_OK;
            r_acc    <= '0;
            r_width  <= '0;
            r_height <= '0;
            r_col    <= ONE;
            r_row    <= ONE;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_err    <= n_err;
            r_acc    <= n_acc;
            r_width  <= n_width;
            r_height <= n_height;
            r_col    <= n_col;
            r_row    <= n_row;
        end
    end
endmodule

[rtl/pbm_ascii_stream_parser_top.sv]
// ============================================================================
// pbm_ascii_stream_parser_top
// Plain PBM (P1) byte-stream parser with valid/ready input and result ports.
// ============================================================================
// The parser takes one file byte (or the end-of-file mark) per clock and
// returns exactly one result item for each, in the cycle after it is accepted.
// Each byte is handled in a single registered pass: the parse state and the
// times-ten accumulate update at the accepting edge and the result lands in
// an output register, so input is taken every cycle as long as the output
// register is empty or being drained in the same cycle. Errors are sticky
// until reset; done_res rises once the file is fully accepted.
module pbm_ascii_stream_parser_top #(
    parameter int MAX_DIM = pbm_pkg::DEF_MAX_DIM
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  pbm_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pbm_pkg::t_out_item o_out_data
);
    import pbm_pkg::*;

    localparam int AW = $clog2(MAX_DIM + 2);

    logic      w_step;
    t_out_item w_item;
    t_out_item r_out;
    logic      r_out_valid, n_out_valid;

    // Accept when the result register is free or draining
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_step     = i_in_valid && o_in_ready;

    pbm_core #(
        .MAX_DIM (MAX_DIM),
        .AW      (AW)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_in    (i_in_data),
        .o_item  (w_item)
    );

    // Fill on accept, drop once taken
    always_comb begin
        if (w_step)           n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
        else                  n_out_valid = r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTH
    // A pixel only comes out of a clean parse, with nonzero coordinates
    a_pixel_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_item.pixel_valid |->
            (w_item.status == ST_OK) && (w_item.column != 12'd0) && (w_item.row != 12'd0))
        else $error("pixel emitted with error or zero coordinate");

    // Done and an error never stand together
    a_done_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.done_res) |-> (r_out.status == ST_OK))
        else $error("done flagged with nonzero status");

    // A stalled result blocks input
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted while result stalled");

    // Every accepted item yields a result next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> r_out_valid)
        else $error("accepted item produced no result");
`endif
endmodule
